@@ rtl/set_assoc_cache_lru_lfu_top_assert.svh @@
`ifndef SET_ASSOC_CACHE_LRU_LFU_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LFU_TOP_ASSERT_SVH
// Assertion macros for the cache block
`ifndef SYNTHESIS
`define SAC_ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define SAC_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define SAC_ASSERT_IMPL(label, a, c)
`define SAC_ASSERT_NEXT(label, a, c)
`endif
`endif

@@ rtl/sac_pkg.sv @@
package sac_pkg;
	localparam int MAX_INDEX_BITS_DEF = 6;
	localparam int MAX_WAYS_DEF = 8;
	localparam int ADDR_W = 64;
	localparam int CNT_W = 32;
	localparam logic [CNT_W-1:0] SAT32 = '1;

	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_FREE  = 2'd1,
		ST_EVICT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_OFFSET = 2'd0,
		REG_INDEX  = 2'd1,
		REG_WAYS   = 2'd2,
		REG_LFU    = 2'd3
	} reg_idx_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == SAT32) ? v : v + CNT_W'(1);
	endfunction
endpackage

@@ rtl/set_assoc_cache_lru_lfu_top.sv @@
// Channel   Dir  Bits   Contents
// s_axis    in   64     tdata: address
// m_axis    out  232    tdata: status, evicted block, filled block, hits, misses, evictions
// cfg       in   8      wr_en, wr_index (2), wr_data (5)
// An access goes through memory read, victim pick, write-back and result in turn.
// One access at a time; s_axis_tready is high only in the idle state.
// After reset a clearing pass sweeps every set of the line memory.
// A result held by m_axis_tready low still lets the next access start.
`include "set_assoc_cache_lru_lfu_top_assert.svh"
module set_assoc_cache_lru_lfu_top #(
	parameter int MAX_INDEX_BITS = sac_pkg::MAX_INDEX_BITS_DEF,
	parameter int MAX_WAYS = sac_pkg::MAX_WAYS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // address
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], evicted_blk[65:2], filled_blk[129:66], hits[161:130],
	// misses[193:162], evictions[225:194], zero fill [231:226]
	output logic [231:0] m_axis_tdata,
	input  logic         wr_en,
	input  logic [1:0]   wr_index,
	input  logic [4:0]   wr_data
);
	import sac_pkg::*;

	localparam int SETS = 1 << MAX_INDEX_BITS;
	localparam int SW = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
	localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int LINE_W = 1 + 2 * ADDR_W + 2 * CNT_W;

	typedef struct packed {
		logic             valid;
		logic [ADDR_W-1:0] tag;
		logic [ADDR_W-1:0] blk;
		logic [CNT_W-1:0]  stamp;
		logic [CNT_W-1:0]  uses;
	} line_t;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_PICK, S_WRITE} state_t;

	logic [4:0] offset_bits_q;
	logic [2:0] index_bits_q;
	logic [3:0] ways_in_use_q;
	logic       lfu_mode_q;

	line_t              line_mem [SETS][MAX_WAYS];
	logic [CNT_W-1:0]   clk_mem [SETS];
	line_t              rd_line_s1 [MAX_WAYS];
	logic [CNT_W-1:0]   rd_clk_s1;

	state_t            state_q;
	logic [SW:0]       clr_cnt_q;
	logic [ADDR_W-1:0] tag_q, blk_q, vblk_q;
	logic [SW-1:0]     set_q;
	logic [WW-1:0]     way_q;
	logic              hit_q;
	logic [1:0]        status_q;
	logic [CNT_W-1:0]  c1_q, hits_q, misses_q, evicts_q;
	logic [3:0]        ways_eff_q;

	logic              out_valid_q;
	logic [231:0]      out_data_q;

	logic [4:0]        ob;
	logic [2:0]        ib;
	logic [3:0]        ways_eff;
	logic [ADDR_W-1:0] a_sh, a_blk, a_tag;
	logic [SW-1:0]     a_set;

	always_comb begin
		ob = offset_bits_q;
		ib = (32'(index_bits_q) > MAX_INDEX_BITS) ? 3'(MAX_INDEX_BITS) : index_bits_q;
		if (ways_in_use_q == 4'd0)
			ways_eff = 4'd1;
		else if (32'(ways_in_use_q) > MAX_WAYS)
			ways_eff = 4'(MAX_WAYS);
		else
			ways_eff = ways_in_use_q;
		a_sh = s_axis_tdata >> ob;
		a_blk = a_sh << ob;
		a_tag = a_sh >> ib;
		a_set = SW'(a_sh & ((64'd1 << ib) - 64'd1));
	end

	// hit search, free search and victim pick over the read set
	logic              f_hit, f_free;
	logic [WW-1:0]     hit_w, free_w, vic_w;
	logic [CNT_W-1:0]  min_u, min_s;

	always_comb begin
		f_hit = 1'b0;
		f_free = 1'b0;
		hit_w = '0;
		free_w = '0;
		vic_w = '0;
		min_u = rd_line_s1[0].uses;
		min_s = rd_line_s1[0].stamp;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (w < 32'(ways_eff_q)) begin
				if (rd_line_s1[w].valid && rd_line_s1[w].tag == tag_q) begin
					f_hit = 1'b1;
					hit_w = WW'(w);
				end
				if (!rd_line_s1[w].valid) begin
					f_free = 1'b1;
					free_w = WW'(w);
				end
			end
		end
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (w < 32'(ways_eff_q)) begin
				if (lfu_mode_q ? (rd_line_s1[w].uses < min_u ||
						(rd_line_s1[w].uses == min_u && rd_line_s1[w].stamp < min_s))
						: (rd_line_s1[w].stamp < min_s)) begin
					min_u = rd_line_s1[w].uses;
					min_s = rd_line_s1[w].stamp;
					vic_w = WW'(w);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 5'd4;
			index_bits_q <= 3'd6;
			ways_in_use_q <= 4'd8;
			lfu_mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_OFFSET: offset_bits_q <= wr_data;
				REG_INDEX:  index_bits_q <= wr_data[2:0];
				REG_WAYS:   ways_in_use_q <= wr_data[3:0];
				REG_LFU:    lfu_mode_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// read port of both memories
	logic          rd_en;
	logic [SW-1:0] rd_addr;
	assign rd_en = s_axis_tvalid && s_axis_tready;
	assign rd_addr = a_set;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_line_s1 <= line_mem[rd_addr];
			rd_clk_s1 <= clk_mem[rd_addr];
		end
	end

	// write port: clearing pass, or write-back of one way
	line_t new_line;
	logic  wb_en;
	logic [CNT_W-1:0] new_clk;

	always_comb begin
		new_line = rd_line_s1[way_q];
		new_clk = c1_q;
		if (hit_q) begin
			if (!lfu_mode_q) begin
				new_clk = sat_inc(c1_q);
				new_line.stamp = new_clk;
			end else begin
				new_line.uses = sat_inc(new_line.uses);
			end
		end else begin
			new_clk = sat_inc(c1_q);
			new_line.valid = 1'b1;
			new_line.tag = tag_q;
			new_line.blk = blk_q;
			new_line.stamp = new_clk;
			new_line.uses = CNT_W'(1);
		end
		// hold write-back while the previous word still waits
		wb_en = (state_q == S_WRITE) && (!out_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			for (int w = 0; w < MAX_WAYS; w++) begin
				line_mem[clr_cnt_q[SW-1:0]][w].valid <= 1'b0;
				line_mem[clr_cnt_q[SW-1:0]][w].stamp <= '0;
				line_mem[clr_cnt_q[SW-1:0]][w].uses <= CNT_W'(1);
			end
			clk_mem[clr_cnt_q[SW-1:0]] <= '0;
		end else if (wb_en) begin
			line_mem[set_q][way_q] <= new_line;
			clk_mem[set_q] <= new_clk;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
			hits_q <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else begin
			if (wb_en)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (32'(clr_cnt_q) == SETS - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (rd_en) begin
						tag_q <= a_tag;
						blk_q <= a_blk;
						set_q <= a_set;
						ways_eff_q <= ways_eff;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					c1_q <= sat_inc(rd_clk_s1);
					hit_q <= f_hit;
					vblk_q <= '0;
					if (f_hit) begin
						way_q <= hit_w;
						status_q <= ST_HIT;
					end else if (f_free) begin
						way_q <= free_w;
						status_q <= ST_FREE;
					end else begin
						way_q <= vic_w;
						vblk_q <= rd_line_s1[vic_w].blk;
						status_q <= ST_EVICT;
					end
					state_q <= S_PICK;
				end
				S_PICK: state_q <= S_WRITE;
				S_WRITE: begin
					if (wb_en) begin
						out_data_q <= {6'd0,
							hit_q ? evicts_q :
								((status_q == ST_EVICT) ? sat_inc(evicts_q) : evicts_q),
							hit_q ? misses_q : sat_inc(misses_q),
							hit_q ? sat_inc(hits_q) : hits_q,
							hit_q ? 64'd0 : blk_q,
							vblk_q, status_q};
						if (hit_q)
							hits_q <= sat_inc(hits_q);
						else
							misses_q <= sat_inc(misses_q);
						if (status_q == ST_EVICT)
							evicts_q <= sat_inc(evicts_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	`SAC_ASSERT_IMPL(a_no_accept_busy, state_q != S_IDLE, !s_axis_tready)
	`SAC_ASSERT_NEXT(a_accept_reads, rd_en, state_q == S_READ)
	`SAC_ASSERT_IMPL(a_status_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
endmodule
